/* rtl/fos_pkg.sv */
package fos_pkg;

	typedef struct packed {
		logic [15:0] front_dist;
		logic [15:0] left_dist_a;
		logic [15:0] left_dist_b;
		logic [15:0] right_dist_a;
		logic [15:0] right_dist_b;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] fwd_speed_cmd;
		logic signed [15:0] yaw_speed_cmd;
	} out_item_t;

	typedef struct packed {
		logic [15:0]        front_full_near_mm;
		logic [15:0]        front_near_end_mm;
		logic [15:0]        side_full_near_mm;
		logic [15:0]        side_near_end_mm;
		logic signed [15:0] reverse_speed;
		logic signed [15:0] forward_speed;
		logic signed [15:0] turn_left_speed;
		logic signed [15:0] turn_right_speed;
	} cfg_regs_t;

	localparam logic [2:0] CFG_FRONT_FULL = 3'd0;
	localparam logic [2:0] CFG_FRONT_END  = 3'd1;
	localparam logic [2:0] CFG_SIDE_FULL  = 3'd2;
	localparam logic [2:0] CFG_SIDE_END   = 3'd3;
	localparam logic [2:0] CFG_REVERSE    = 3'd4;
	localparam logic [2:0] CFG_FORWARD    = 3'd5;
	localparam logic [2:0] CFG_TURN_LEFT  = 3'd6;
	localparam logic [2:0] CFG_TURN_RIGHT = 3'd7;

	localparam logic [1:0] MU_FULL = 2'd0;
	localparam logic [1:0] MU_ZERO = 2'd1;
	localparam logic [1:0] MU_DIV  = 2'd2;

	localparam int YAW_Q_W = 17;

endpackage

/* rtl/fos_div.sv */
module fos_div #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 16,
	parameter int Q_W   = 15,
	parameter int TAG_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic [TAG_W-1:0] tag_out
);

	logic             vld_s [Q_W+1];
	logic [DEN_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0]   lo_s  [Q_W+1];
	logic [Q_W-1:0]   quo_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [TAG_W-1:0] tag_s [Q_W+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = DEN_W'(num >> Q_W);
	assign lo_s[0]  = num[Q_W-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign tag_s[0] = tag;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;
		assign trial = {rem_s[k], lo_s[k][Q_W-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? DEN_W'(trial - {1'b0, den_s[k]}) : DEN_W'(trial);
			lo_s[k+1]  <= lo_s[k] << 1;
			quo_s[k+1] <= {quo_s[k][Q_W-2:0], ge};
			den_s[k+1] <= den_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = vld_s[Q_W];
	assign quo       = quo_s[Q_W];
	assign tag_out   = tag_s[Q_W];

endmodule

/* rtl/fos_front.sv */
module fos_front #(
	parameter int DIST_BITS = 16,
	parameter int ENT_W = 3 * (2 + 2 * DIST_BITS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fos_pkg::in_item_t in_item,
	input  fos_pkg::cfg_regs_t cfg,
	output logic              push,
	output logic [ENT_W-1:0]  push_data,
	input  logic              push_ready
);

	localparam int D = DIST_BITS;

	logic             vld_s1;
	logic [ENT_W-1:0] ent_s1;
	logic             advance;
	logic [D:0]       lsum;
	logic [D:0]       rsum;
	logic [D-1:0]     left;
	logic [D-1:0]     right;

	function automatic logic [2*D+1:0] classify(input logic [D-1:0] x,
			input logic [D-1:0] full, input logic [D-1:0] stop);
		logic [1:0] sel;
		if (x <= full) begin
			sel = fos_pkg::MU_FULL;
		end else if (x >= stop) begin
			sel = fos_pkg::MU_ZERO;
		end else begin
			sel = fos_pkg::MU_DIV;
		end
		return {sel, D'(stop - x), D'(stop - full)};
	endfunction

	assign lsum  = (D+1)'(D'(in_item.left_dist_a)) + (D+1)'(D'(in_item.left_dist_b));
	assign rsum  = (D+1)'(D'(in_item.right_dist_a)) + (D+1)'(D'(in_item.right_dist_b));
	assign left  = lsum[D:1];
	assign right = rsum[D:1];

	assign advance = !vld_s1 || push_ready;
	assign busy    = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && start) begin
			ent_s1 <= {classify(D'(in_item.front_dist), D'(cfg.front_full_near_mm),
					D'(cfg.front_near_end_mm)),
				classify(left, D'(cfg.side_full_near_mm), D'(cfg.side_near_end_mm)),
				classify(right, D'(cfg.side_full_near_mm), D'(cfg.side_near_end_mm))};
		end
	end

	assign push      = vld_s1 && push_ready;
	assign push_data = ent_s1;

endmodule

/* rtl/fos_queue.sv */
module fos_queue #(
	parameter int ENT_W = 102
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [ENT_W-1:0] push_data,
	output logic             push_ready,
	output logic             pop,
	output logic [ENT_W-1:0] pop_data
);

	logic [ENT_W-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign push_ready = cnt_q != 2'd2;
	assign pop        = cnt_q != 2'd0;
	assign pop_data   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/fos_back.sv */
module fos_back #(
	parameter int DIST_BITS = 16,
	parameter int FRAC_BITS = 15,
	parameter int ENT_W = 3 * (2 + 2 * DIST_BITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop,
	input  logic [ENT_W-1:0]   pop_data,
	input  fos_pkg::cfg_regs_t cfg,
	output logic               result_valid,
	output fos_pkg::out_item_t result
);

	localparam int D  = DIST_BITS;
	localparam int F  = FRAC_BITS;
	localparam int CW = 2 + 2 * D;
	localparam int NW = D + F;
	localparam int YW = F + 18;
	localparam int QW = fos_pkg::YAW_Q_W;
	localparam int TW = 18;

	logic [CW-1:0] ch [3];
	logic          dvld [3];
	logic [F-1:0]  dq [3];
	logic [1:0]    dsel [3];
	logic [F:0]    mu [3];

	assign ch[0] = pop_data[3*CW-1:2*CW];
	assign ch[1] = pop_data[2*CW-1:CW];
	assign ch[2] = pop_data[CW-1:0];

	for (genvar i = 0; i < 3; i++) begin : g_mu
		fos_div #(.NUM_W(NW), .DEN_W(D), .Q_W(F), .TAG_W(2)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (pop),
			.num      ({ch[i][2*D-1:D], F'(0)}),
			.den      (ch[i][D-1:0]),
			.tag      (ch[i][CW-1:CW-2]),
			.out_valid(dvld[i]),
			.quo      (dq[i]),
			.tag_out  (dsel[i])
		);

		always_comb begin
			case (dsel[i])
				fos_pkg::MU_FULL: mu[i] = (F+1)'(1) << F;
				fos_pkg::MU_DIV:  mu[i] = {1'b0, dq[i]};
				default:          mu[i] = '0;
			endcase
		end
	end

	logic                 vld_s2;
	logic signed [F+19:0] fprod_s2;
	logic signed [YW-1:0] ynum_s2;
	logic [F+1:0]         wsum_s2;

	logic signed [16:0] sdiff;
	assign sdiff = 17'(cfg.reverse_speed) - 17'(cfg.forward_speed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= dvld[0];
		end
	end

	always_ff @(posedge clk) begin
		fprod_s2 <= (F+20)'($signed({1'b0, mu[0]}) * sdiff);
		ynum_s2  <= YW'($signed({1'b0, mu[1]}) * cfg.turn_right_speed)
			+ YW'($signed({1'b0, mu[2]}) * cfg.turn_left_speed);
		wsum_s2  <= (F+2)'(mu[1]) + (F+2)'(mu[2]);
	end

	logic signed [F+19:0] fsum;
	logic signed [19:0]   fflr;
	logic signed [15:0]   fsat;
	logic [YW-1:0]        yabs;
	logic [TW-1:0]        ytag;

	assign fsum = fprod_s2 + ((F+20)'(cfg.forward_speed) <<< F);
	assign fflr = 20'(fsum >>> F);
	assign fsat = (fflr > 20'sd32767) ? 16'sd32767 :
		(fflr < -20'sd32768) ? -16'sd32768 : 16'(fflr);
	assign yabs = ynum_s2[YW-1] ? YW'(-ynum_s2) : YW'(ynum_s2);
	assign ytag = {fsat, ynum_s2[YW-1], wsum_s2 == '0};

	logic          yvld;
	logic [QW-1:0] yq;
	logic [TW-1:0] yt;

	fos_div #(.NUM_W(YW), .DEN_W(F + 2), .Q_W(QW), .TAG_W(TW)) u_ydiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.num      (yabs),
		.den      (wsum_s2),
		.tag      (ytag),
		.out_valid(yvld),
		.quo      (yq),
		.tag_out  (yt)
	);

	logic signed [QW:0] ysgn;
	logic signed [15:0] ysat;

	assign ysgn = yt[1] ? -$signed({1'b0, yq}) : $signed({1'b0, yq});
	assign ysat = yt[0] ? 16'sd0 :
		(ysgn > (QW+1)'(32767)) ? 16'sd32767 :
		(ysgn < -(QW+1)'(32768)) ? -16'sd32768 : 16'(ysgn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= yvld;
		end
	end

	always_ff @(posedge clk) begin
		result.fwd_speed_cmd <= yt[TW-1:2];
		result.yaw_speed_cmd <= ysat;
	end

endmodule

/* rtl/fuzzy_obstacle_steer_unit.sv */
// Throughput: one item per cycle; the nearness and yaw dividers are pipelined one bit a stage.
// busy stays low in use, since the back end takes a queue entry every cycle.
// Reset (arst_n low, asynchronous) empties the pipeline and queue and loads the default
// register values; the receiver cannot stall and takes each result in its strobe cycle.
module fuzzy_obstacle_steer_unit #(
	parameter int DIST_BITS = 16,
	parameter int FRAC_BITS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fos_pkg::in_item_t  in_item,
	output logic               result_valid,
	output fos_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int ENT_W = 3 * (2 + 2 * DIST_BITS);

	fos_pkg::cfg_regs_t cfg_q;
	logic [15:0]        dist_val;

	assign cfg_ready = 1'b1;
	assign dist_val  = 16'(DIST_BITS'(cfg_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_full_near_mm <= 16'd150;
			cfg_q.front_near_end_mm  <= 16'd200;
			cfg_q.side_full_near_mm  <= 16'd100;
			cfg_q.side_near_end_mm   <= 16'd150;
			cfg_q.reverse_speed      <= -16'sd32768;
			cfg_q.forward_speed      <= 16'sd32767;
			cfg_q.turn_left_speed    <= 16'sd26214;
			cfg_q.turn_right_speed   <= -16'sd26214;
		end else if (cfg_valid) begin
			case (cfg_index)
				fos_pkg::CFG_FRONT_FULL: cfg_q.front_full_near_mm <= dist_val;
				fos_pkg::CFG_FRONT_END:  cfg_q.front_near_end_mm  <= dist_val;
				fos_pkg::CFG_SIDE_FULL:  cfg_q.side_full_near_mm  <= dist_val;
				fos_pkg::CFG_SIDE_END:   cfg_q.side_near_end_mm   <= dist_val;
				fos_pkg::CFG_REVERSE:    cfg_q.reverse_speed      <= cfg_data;
				fos_pkg::CFG_FORWARD:    cfg_q.forward_speed      <= cfg_data;
				fos_pkg::CFG_TURN_LEFT:  cfg_q.turn_left_speed    <= cfg_data;
				fos_pkg::CFG_TURN_RIGHT: cfg_q.turn_right_speed   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic             push;
	logic             push_ready;
	logic [ENT_W-1:0] push_data;
	logic             pop;
	logic [ENT_W-1:0] pop_data;

	fos_front #(.DIST_BITS(DIST_BITS), .ENT_W(ENT_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready)
	);

	fos_queue #(.ENT_W(ENT_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	fos_back #(.DIST_BITS(DIST_BITS), .FRAC_BITS(FRAC_BITS), .ENT_W(ENT_W)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop         (pop),
		.pop_data    (pop_data),
		.cfg         (cfg_q),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
